### rtl/core/avts_pkg.sv
// ----------------------------------------------------------------------------
// avts_pkg: shared types and constants
// Operation codes, sequencer states and defaults for the timestamp queues.
// ----------------------------------------------------------------------------
package avts_pkg;

  localparam int QueueDepthDefault = 32;
  localparam int TimeW  = 63;
  localparam int IdxW   = 6;
  localparam int RegW   = 32;
  localparam int CfgIdxW = 2;

  localparam logic [RegW-1:0] TolReset = 32'd50000;
  localparam logic [RegW-1:0] WinReset = 32'd1000000;

  typedef enum logic [2:0] {
    OP_PUSH_V  = 3'd0,
    OP_PUSH_A  = 3'd1,
    OP_ZONE    = 3'd2,
    OP_MARK_V  = 3'd3,
    OP_MARK_A  = 3'd4,
    OP_CLEANUP = 3'd5,
    OP_CLEAR   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    CFG_TOL = 2'd0,
    CFG_WIN = 2'd1,
    CFG_VLIM = 2'd2,
    CFG_ALIM = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DROP, S_WRITE, S_MARK, S_CLR,
    S_CL_RD, S_CL_CHK,
    S_Z_RD0, S_Z_RD1, S_Z_EVAL, S_Z_CMP,
    S_Z_SRD, S_Z_SCHK,
    S_OUT
  } state_t;

endpackage

### rtl/core/avts_ram.sv
// ----------------------------------------------------------------------------
// avts_ram: generic single-port-write RAM
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module avts_ram #(
  parameter int Width = 63,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/av_timestamp_sync_queues.sv
// ----------------------------------------------------------------------------
// av_timestamp_sync_queues: video/audio timestamp queues with zone search
// Two bounded ring queues of timestamps with processed flags, a zone search
// over both, mark, cleanup and clear operations.
// ----------------------------------------------------------------------------
// Usage: one command transaction on s_axis (tdata holds operation,
// capture_time, range_start, range_end) yields exactly one status transaction
// on m_axis. Configuration is written over cfg_we/cfg_index/cfg_data while
// idle. A small sequencer drives one shared 66-bit subtract unit and one
// timestamp RAM per queue (registered read).
// Commands: push, mark (walks range_start to range_end-1 when the range
// applies), clear, cleanup (pops per queue) and zone; an unused code, or
// zone with an empty queue, goes straight to status. Zone scans the
// entries of both queues only when a zone is found. Each entry check
// waits for the registered RAM read.
// s_axis_tready is low while a command is in progress or its status is not
// yet taken; the next command is accepted the cycle after the status
// transaction. A stalled m_axis holds the status stable.
// Reset empties both queues, clears flags and latest times, and loads the
// register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module av_timestamp_sync_queues #(
  parameter int QUEUE_DEPTH = avts_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // operation[2:0], capture_time[65:3], range_start[71:66], range_end[77:72]
  input  logic [79:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // zone_valid[0], zone_begin[63:1], zone_finish[126:64],
  // video_first_index[132:127], video_stop_index[138:133],
  // audio_first_index[144:139], audio_stop_index[150:145],
  // video_occupancy[156:151], audio_occupancy[162:157], range_applied[163]
  output logic [167:0]  m_axis_tdata,
  input  logic          cfg_we,
  input  logic [avts_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [avts_pkg::RegW-1:0]    cfg_data
);
  import avts_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // configuration
  logic [RegW-1:0] tol, win;
  logic [IdxW-1:0] vlim_reg, alim_reg;
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TolReset;
      win <= WinReset;
      vlim_reg <= IdxW'(32);
      alim_reg <= IdxW'(32);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TOL:  tol <= cfg_data;
        CFG_WIN:  win <= cfg_data;
        CFG_VLIM: vlim_reg <= cfg_data[IdxW-1:0];
        CFG_ALIM: alim_reg <= cfg_data[IdxW-1:0];
        default: ;
      endcase
    end
  end

  // state
  state_t state, state_next;
  logic [TimeW-1:0] ctime;
  logic [IdxW-1:0] re;
  logic [AW-1:0] head [2];
  logic [CW-1:0] cnt [2];
  logic [TimeW-1:0] latest [2];
  logic [QUEUE_DEPTH-1:0] done [2];
  logic sel;              // 0 video, 1 audio
  logic [CW-1:0] idx;
  logic found;
  logic [TimeW-1:0] vs, ve, as_t, ae, zs, ze;
  logic zvalid;
  logic [IdxW-1:0] first [2], stop [2];
  logic applied;
  logic signed [65:0] thr;

  // command decode
  logic accept;
  op_t cmd_op;
  logic is_mark, mark_ok, zone_empty;
  logic [CW-1:0] mark_cnt;

  // queue addressing
  logic [CW-1:0] lim, csel, drop_n;
  logic [IdxW-1:0] limr;
  logic [AW-1:0] hsel, waddr, cur_slot;
  logic [CW:0] idx_inc;
  logic mark_last, scan_last;

  // RAMs
  logic we [2];
  logic [CW-1:0] ridx [2];
  logic [AW-1:0] raddr [2];
  logic [TimeW-1:0] rdata [2];
  logic [TimeW-1:0] rd_sel;

  // shared subtract unit
  logic signed [65:0] alu_a, alu_b, alu_d;
  logic cl_pop, z_gap_hi, z_overlap, z_gap_ok;
  logic [149:0] zone_bits;

  function automatic logic [AW-1:0] slot(logic [AW-1:0] h, logic [CW-1:0] i);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, i};
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  for (genvar g = 0; g < 2; g++) begin : g_ram
    assign ridx[g] = (state == S_Z_RD1) ? cnt[g] - 1'b1 : idx;
    assign raddr[g] = slot(head[g], ridx[g]);
    avts_ram #(.Width(TimeW), .Depth(QUEUE_DEPTH)) u_ram (
      .clk(clk), .we(we[g]), .waddr(waddr), .wdata(ctime),
      .raddr(raddr[g]), .rdata(rdata[g]));
  end

  assign alu_d = alu_a - alu_b;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign cmd_op = op_t'(s_axis_tdata[2:0]);
  assign is_mark = (cmd_op == OP_MARK_V) || (cmd_op == OP_MARK_A);
  assign mark_cnt = (cmd_op == OP_MARK_A) ? cnt[1] : cnt[0];
  assign mark_ok = (s_axis_tdata[77:72] > s_axis_tdata[71:66]) &&
                   (16'(s_axis_tdata[77:72]) <= 16'(mark_cnt));
  assign zone_empty = (cnt[0] == '0) || (cnt[1] == '0);

  assign limr = sel ? alim_reg : vlim_reg;
  always_comb begin
    if (limr == '0) lim = CW'(1);
    else if (16'(limr) > 16'(QUEUE_DEPTH)) lim = CW'(QUEUE_DEPTH);
    else lim = CW'(limr);
  end

  assign csel = cnt[sel];
  assign hsel = head[sel];
  assign drop_n = csel - lim + CW'(1);
  assign waddr = slot(hsel, csel);
  assign cur_slot = slot(hsel, idx);
  assign idx_inc = {1'b0, idx} + (CW+1)'(1);
  assign mark_last = idx_inc >= (CW+1)'(re);
  assign scan_last = idx_inc >= {1'b0, csel};
  assign rd_sel = sel ? rdata[1] : rdata[0];

  assign cl_pop = (csel != '0) && done[sel][hsel] && (alu_d > 66'sd0);
  assign z_gap_hi = vs > ae;
  assign z_overlap = ze > zs;
  assign z_gap_ok = (alu_d >= 66'sd0) && (alu_d <= $signed({34'b0, tol}));

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    state_next = state;
    we[0] = 1'b0;
    we[1] = 1'b0;
    alu_a = '0;
    alu_b = '0;
    if (state == S_CL_RD) begin
      alu_a = {3'b0, latest[sel]};
      alu_b = {34'b0, win};
    end else if (state == S_CL_CHK) begin
      alu_a = thr;
      alu_b = {3'b0, rd_sel};
    end else if (state == S_Z_CMP) begin
      alu_a = {3'b0, (z_gap_hi ? vs : as_t)};
      alu_b = {3'b0, (z_gap_hi ? ae : ve)};
    end
    unique case (state)
      S_IDLE: if (accept) begin
        unique case (cmd_op)
          OP_PUSH_V, OP_PUSH_A: state_next = S_DROP;
          OP_ZONE: state_next = zone_empty ? S_OUT : S_Z_RD0;
          OP_MARK_V, OP_MARK_A: state_next = S_MARK;
          OP_CLEANUP: state_next = S_CL_RD;
          OP_CLEAR: state_next = S_CLR;
          OP_NONE: state_next = S_OUT;
          default: state_next = S_OUT;
        endcase
      end
      S_DROP: state_next = S_WRITE;
      S_WRITE: begin
        we[0] = !sel;
        we[1] = sel;
        state_next = S_OUT;
      end
      S_MARK: if (!applied || mark_last) state_next = S_OUT;
      S_CLR: state_next = S_OUT;
      S_CL_RD: state_next = S_CL_CHK;
      S_CL_CHK: state_next = (cl_pop || !sel) ? S_CL_RD : S_OUT;
      S_Z_RD0: state_next = S_Z_RD1;
      S_Z_RD1: state_next = S_Z_EVAL;
      S_Z_EVAL: state_next = S_Z_CMP;
      S_Z_CMP: state_next = (z_overlap || z_gap_ok) ? S_Z_SRD : S_OUT;
      S_Z_SRD: state_next = S_Z_SCHK;
      S_Z_SCHK: state_next = (scan_last && sel) ? S_OUT : S_Z_SRD;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head[0] <= '0; head[1] <= '0;
      cnt[0] <= '0; cnt[1] <= '0;
      latest[0] <= '0; latest[1] <= '0;
      done[0] <= '0; done[1] <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          ctime <= s_axis_tdata[65:3];
          re <= s_axis_tdata[77:72];
          sel <= (cmd_op == OP_PUSH_A) || (cmd_op == OP_MARK_A);
          zvalid <= 1'b0;
          applied <= is_mark && mark_ok;
          found <= 1'b0;
          first[0] <= '0; first[1] <= '0; stop[0] <= '0; stop[1] <= '0;
          idx <= is_mark ? CW'(s_axis_tdata[71:66]) : '0;
        end
        S_DROP: if (csel >= lim) begin
          head[sel] <= slot(hsel, drop_n);
          cnt[sel] <= lim - 1'b1;
        end
        S_WRITE: begin
          done[sel][waddr] <= 1'b0;
          cnt[sel] <= csel + 1'b1;
          if (ctime > latest[sel]) latest[sel] <= ctime;
        end
        S_MARK: if (applied) begin
          done[sel][cur_slot] <= 1'b1;
          idx <= idx + 1'b1;
        end
        S_CLR: begin
          head[0] <= '0; head[1] <= '0;
          cnt[0] <= '0; cnt[1] <= '0;
          latest[0] <= '0; latest[1] <= '0;
          done[0] <= '0; done[1] <= '0;
        end
        // threshold = latest - window; pop while the head entry is processed and its time < threshold
        S_CL_RD: thr <= alu_d;
        S_CL_CHK: begin
          if (cl_pop) begin
            head[sel] <= slot(hsel, CW'(1));
            cnt[sel] <= csel - 1'b1;
          end else begin
            sel <= 1'b1;
          end
        end
        S_Z_RD0: ;
        S_Z_RD1: begin
          vs <= rdata[0];
          as_t <= rdata[1];
        end
        S_Z_EVAL: begin
          ve <= rdata[0];
          ae <= rdata[1];
          zs <= (vs > as_t) ? vs : as_t;
          ze <= (rdata[0] < rdata[1]) ? rdata[0] : rdata[1];
        end
        S_Z_CMP: begin
          if (z_overlap) begin
            zvalid <= 1'b1;
          end else if (z_gap_ok) begin
            zs <= (vs < as_t) ? vs : as_t;
            ze <= (ve > ae) ? ve : ae;
            zvalid <= 1'b1;
          end else begin
            zvalid <= 1'b0;
          end
          sel <= 1'b0;
          idx <= '0;
          found <= 1'b0;
        end
        S_Z_SRD: ;
        S_Z_SCHK: begin
          if (!found && rd_sel >= zs) first[sel] <= IdxW'(idx);
          if (rd_sel <= ze) stop[sel] <= IdxW'(idx_inc);
          if (scan_last && !sel) found <= 1'b0;
          else if (rd_sel >= zs) found <= 1'b1;
          if (scan_last) begin
            sel <= 1'b1;
            idx <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  // output register
  assign zone_bits = {stop[1], first[1], stop[0], first[0], ze, zs};
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      m_axis_tdata <= {4'b0, applied, IdxW'(cnt[1]), IdxW'(cnt[0]),
                       (zvalid ? zone_bits : 150'b0), zvalid};
    end
  end

  property p_ready_idle;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !s_axis_tready;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready while busy");
  a_cnt_v: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= CW'(QUEUE_DEPTH)) else $error("video count overflow");
  a_cnt_a: assert property (@(posedge clk) disable iff (rst)
    cnt[1] <= CW'(QUEUE_DEPTH)) else $error("audio count overflow");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> m_axis_tvalid) else $error("status lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("status changed while stalled");
endmodule
